// ----- hdl/ffsa_pkg.sv -----
// Package for the first-fit segment allocator: sizes, status codes, commands, entry type, FSM states.
// Used by the allocator top level and its checker.
`default_nettype none
package ffsa_pkg;
    localparam int SEGMENT_BYTES = 1024;
    localparam int SEGMENT_COUNT = 8;
    localparam int ENTRIES_PER_SEGMENT = 64;
    localparam int SEG_W = 3;
    localparam int OFF_W = 10;
    localparam int SIZE_W = 11;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam int ADDR_W = SEG_W + IDX_W;
    localparam int ENTRY_W = OFF_W + SIZE_W + 1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [1:0] ST_NO_MEMORY = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE = 1'b1;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic [SIZE_W-1:0] size;
        logic free;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ASEG,     // pick next active segment or open a new one
        S_ARD,      // read wait for alloc scan
        S_ACHK,     // examine entry
        S_SHRD,     // shift up: read entry k-1
        S_SHWR,     // shift up: write entry k
        S_FRD,      // free scan read wait
        S_FCHK,
        S_MLRD,     // walk down to first
        S_MLCHK,
        S_MRRD,     // walk up to last, accumulate
        S_MRCHK,
        S_CPRD,     // compaction copy read
        S_CPWR,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

// ----- hdl/ffsa_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ----- hdl/first_fit_segment_allocator.sv -----
// First-fit segment allocator with coalescing; one result word per command word.
// A rejected size or an unknown segment gives its result the cycle after acceptance.
// An alloc visits segments, scans entries and shifts entries up for a split; the
// worst alloc scans all 512 entries. A free scans, walks and moves entries.
// One command at a time; s_tready is high only while idle. Reset clears the counts
// and active marks at once; the RAM is not cleared.
`default_nettype none
module first_fit_segment_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: request_size[10:0], free_segment[13:11], free_offset[23:14]
    input  wire logic [23:0] s_tdata,
    // tuser: command
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: status[1:0], granted_segment[4:2], granted_offset[14:5], granted_size[25:15]
    output logic [31:0]      m_tdata
);
    localparam int SB = ffsa_pkg::SEGMENT_BYTES;
    localparam int EPS = ffsa_pkg::ENTRIES_PER_SEGMENT;

    ffsa_pkg::state_t state_reg, state_next;
    logic [ffsa_pkg::CNT_W-1:0] count_reg [ffsa_pkg::SEGMENT_COUNT];
    logic [ffsa_pkg::SEGMENT_COUNT-1:0] active_reg;

    logic [ffsa_pkg::SIZE_W-1:0] req_reg, tot_reg;
    logic [ffsa_pkg::OFF_W-1:0] foff_reg;
    logic [ffsa_pkg::SEG_W-1:0] seg_reg;
    logic [ffsa_pkg::CNT_W-1:0] i_reg, k_reg, first_reg, last_reg;
    ffsa_pkg::entry_t hold_reg;
    logic [1:0] st_reg;
    logic [ffsa_pkg::SEG_W-1:0] gseg_reg;
    logic [ffsa_pkg::OFF_W-1:0] goff_reg;
    logic [ffsa_pkg::SIZE_W-1:0] gsize_reg;
    logic [1:0] sub_reg;    // final-write flag (split remainder or merged head) / open-new flag

    logic we;
    logic [ffsa_pkg::ADDR_W-1:0] addr;
    ffsa_pkg::entry_t wdata, rdata;
    logic [ffsa_pkg::ENTRY_W-1:0] rraw;

    ffsa_ram #(.WIDTH(ffsa_pkg::ENTRY_W), .DEPTH(ffsa_pkg::SEGMENT_COUNT * EPS)) u_ram (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rraw)
    );
    assign rdata = ffsa_pkg::entry_t'(rraw);

    logic [ffsa_pkg::CNT_W-1:0] n_cur;
    assign n_cur = count_reg[seg_reg];

    function automatic logic [ffsa_pkg::ADDR_W-1:0] ea(
        input logic [ffsa_pkg::SEG_W-1:0] s, input logic [ffsa_pkg::CNT_W-1:0] i);
        ea = {s, i[ffsa_pkg::IDX_W-1:0]};
    endfunction

    // Lowest active segment at or above seg_reg, and lowest inactive segment.
    logic act_found, inact_found;
    logic [ffsa_pkg::SEG_W-1:0] act_seg, inact_seg;
    always_comb
    begin
        act_found = 1'b0;
        act_seg = '0;
        inact_found = 1'b0;
        inact_seg = '0;
        for (int s = ffsa_pkg::SEGMENT_COUNT - 1; s >= 0; s--)
        begin
            if (active_reg[s] && ffsa_pkg::SEG_W'(s) >= seg_reg)
            begin
                act_found = 1'b1;
                act_seg = ffsa_pkg::SEG_W'(s);
            end
            if (!active_reg[s])
            begin
                inact_found = 1'b1;
                inact_seg = ffsa_pkg::SEG_W'(s);
            end
        end
    end

    logic fits, split;
    assign fits = rdata.free && (rdata.size >= req_reg);
    assign split = (rdata.size > req_reg) && (n_cur < ffsa_pkg::CNT_W'(EPS));

    assign s_tready = (state_reg == ffsa_pkg::S_IDLE);
    assign m_tvalid = (state_reg == ffsa_pkg::S_OUT);
    assign m_tdata = {6'd0, gsize_reg, goff_reg, gseg_reg, st_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffsa_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == ffsa_pkg::CMD_ALLOC)
                    begin
                        if (s_tdata[10:0] == '0 || s_tdata[10:0] > ffsa_pkg::SIZE_W'(SB))
                            state_next = ffsa_pkg::S_OUT;
                        else
                            state_next = ffsa_pkg::S_ASEG;
                    end
                    else if (!active_reg[s_tdata[13:11]] || count_reg[s_tdata[13:11]] == '0)
                        state_next = ffsa_pkg::S_OUT;
                    else
                        state_next = ffsa_pkg::S_FRD;
                end
            end
            ffsa_pkg::S_ASEG:
            begin
                if (sub_reg[0] || act_found || inact_found)
                    state_next = ffsa_pkg::S_ARD;
                else
                    state_next = ffsa_pkg::S_OUT;
            end
            ffsa_pkg::S_ARD: state_next = ffsa_pkg::S_ACHK;
            ffsa_pkg::S_ACHK:
            begin
                if (fits)
                    state_next = split && (n_cur > i_reg + 1'b1) ? ffsa_pkg::S_SHRD
                                                                  : ffsa_pkg::S_OUT;
                else if (i_reg + 1'b1 < n_cur)
                    state_next = ffsa_pkg::S_ARD;
                else if (sub_reg[0] ||
                         seg_reg == ffsa_pkg::SEG_W'(ffsa_pkg::SEGMENT_COUNT - 1))
                    state_next = ffsa_pkg::S_OUT;
                else
                    state_next = ffsa_pkg::S_ASEG;
            end
            ffsa_pkg::S_SHRD: state_next = ffsa_pkg::S_SHWR;
            ffsa_pkg::S_SHWR:
                state_next = (k_reg - 1'b1 > i_reg + 1'b1) ? ffsa_pkg::S_SHRD : ffsa_pkg::S_OUT;
            ffsa_pkg::S_FRD: state_next = ffsa_pkg::S_FCHK;
            ffsa_pkg::S_FCHK:
            begin
                if (rdata.offset == foff_reg)
                    state_next = (i_reg != '0) ? ffsa_pkg::S_MLRD : ffsa_pkg::S_MRRD;
                else if (i_reg + 1'b1 < n_cur)
                    state_next = ffsa_pkg::S_FRD;
                else
                    state_next = ffsa_pkg::S_OUT;
            end
            ffsa_pkg::S_MLRD: state_next = ffsa_pkg::S_MLCHK;
            ffsa_pkg::S_MLCHK:
                state_next = (rdata.free && first_reg > 1) ? ffsa_pkg::S_MLRD
                                                           : ffsa_pkg::S_MRRD;
            ffsa_pkg::S_MRRD: state_next = ffsa_pkg::S_MRCHK;
            ffsa_pkg::S_MRCHK:
            begin
                if (k_reg == first_reg || k_reg <= i_reg || (rdata.free && k_reg < n_cur))
                    state_next = ffsa_pkg::S_MRRD;
                else
                    state_next = ffsa_pkg::S_CPRD;
            end
            ffsa_pkg::S_CPRD: state_next = ffsa_pkg::S_CPWR;
            // The count already holds the merged value here.
            ffsa_pkg::S_CPWR:
                state_next = (k_reg + 1'b1 < n_cur) ? ffsa_pkg::S_CPRD : ffsa_pkg::S_OUT;
            ffsa_pkg::S_OUT: if (m_tready) state_next = ffsa_pkg::S_IDLE;
            default: state_next = ffsa_pkg::S_IDLE;
        endcase
    end

    // RAM port control.
    always_comb
    begin
        we = 1'b0;
        addr = ea(seg_reg, i_reg);
        wdata = hold_reg;
        case (state_reg)
            ffsa_pkg::S_ASEG:
            begin
                if (sub_reg[0])
                    addr = ea(seg_reg, '0);
                else if (act_found)
                    addr = ea(act_seg, '0);
                else
                begin
                    // Open a fresh segment: write one free block spanning it.
                    we = inact_found;
                    addr = ea(inact_seg, '0);
                    wdata = '{offset: '0, size: ffsa_pkg::SIZE_W'(SB), free: 1'b1};
                end
            end
            ffsa_pkg::S_ARD, ffsa_pkg::S_FRD: addr = ea(seg_reg, i_reg);
            ffsa_pkg::S_ACHK:
            begin
                if (fits)
                begin
                    // Entry i becomes allocated; after a split the remainder is written to entry
                    // i+1 in S_OUT, after any shift of the entries above.
                    we = 1'b1;
                    addr = ea(seg_reg, i_reg);
                    wdata = '{offset: rdata.offset,
                              size: split ? req_reg : rdata.size, free: 1'b0};
                end
                else
                    addr = ea(seg_reg, i_reg + 1'b1);
            end
            ffsa_pkg::S_SHRD: addr = ea(seg_reg, k_reg - 1'b1);
            ffsa_pkg::S_SHWR:
            begin
                we = 1'b1;
                addr = ea(seg_reg, k_reg);
                wdata = rdata;
            end
            ffsa_pkg::S_FCHK: addr = ea(seg_reg, i_reg + 1'b1);
            ffsa_pkg::S_MLRD: addr = ea(seg_reg, first_reg - 1'b1);
            ffsa_pkg::S_MRRD: addr = ea(seg_reg, k_reg);
            ffsa_pkg::S_CPRD: addr = ea(seg_reg, k_reg + (last_reg - first_reg));
            ffsa_pkg::S_CPWR:
            begin
                we = 1'b1;
                addr = ea(seg_reg, k_reg);
                wdata = rdata;
            end
            ffsa_pkg::S_OUT:
            begin
                // Final write: remainder after a split, or merged head after a free.
                we = sub_reg[1];
                addr = ea(seg_reg, first_reg);
                wdata = hold_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffsa_pkg::S_IDLE;
            active_reg <= '0;
            for (int s = 0; s < ffsa_pkg::SEGMENT_COUNT; s++)
                count_reg[s] <= '0;
            sub_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ffsa_pkg::S_IDLE:
                begin
                    sub_reg <= '0;
                    if (s_tvalid)
                    begin
                        req_reg <= s_tdata[10:0];
                        foff_reg <= s_tdata[23:14];
                        i_reg <= '0;
                        st_reg <= ffsa_pkg::ST_OK;
                        gseg_reg <= '0;
                        goff_reg <= '0;
                        gsize_reg <= '0;
                        if (s_tuser == ffsa_pkg::CMD_ALLOC)
                        begin
                            seg_reg <= '0;
                            if (s_tdata[10:0] == '0 || s_tdata[10:0] > ffsa_pkg::SIZE_W'(SB))
                                st_reg <= ffsa_pkg::ST_BAD_SIZE;
                        end
                        else
                        begin
                            seg_reg <= s_tdata[13:11];
                            if (!active_reg[s_tdata[13:11]] || count_reg[s_tdata[13:11]] == '0)
                                st_reg <= ffsa_pkg::ST_NOT_FOUND;
                        end
                    end
                end
                ffsa_pkg::S_ASEG:
                begin
                    i_reg <= '0;
                    if (sub_reg[0])
                        ;
                    else if (act_found)
                        seg_reg <= act_seg;
                    else if (inact_found)
                    begin
                        seg_reg <= inact_seg;
                        active_reg[inact_seg] <= 1'b1;
                        count_reg[inact_seg] <= ffsa_pkg::CNT_W'(1);
                        sub_reg[0] <= 1'b1;
                    end
                    else
                        st_reg <= ffsa_pkg::ST_NO_MEMORY;
                end
                ffsa_pkg::S_ACHK:
                begin
                    if (fits)
                    begin
                        gseg_reg <= seg_reg;
                        goff_reg <= rdata.offset;
                        gsize_reg <= split ? req_reg : rdata.size;
                        k_reg <= n_cur;
                        first_reg <= i_reg + 1'b1;
                        hold_reg <= '{offset: rdata.offset + req_reg[ffsa_pkg::OFF_W-1:0],
                                      size: rdata.size - req_reg, free: 1'b1};
                        if (split)
                        begin
                            sub_reg[1] <= 1'b1;
                            count_reg[seg_reg] <= n_cur + 1'b1;
                        end
                    end
                    else if (i_reg + 1'b1 < n_cur)
                        i_reg <= i_reg + 1'b1;
                    // Active segments form a prefix, so the last one being active
                    // means every segment was searched and none is left to open.
                    else if (sub_reg[0] ||
                             seg_reg == ffsa_pkg::SEG_W'(ffsa_pkg::SEGMENT_COUNT - 1))
                        st_reg <= ffsa_pkg::ST_NO_MEMORY;
                    else
                        seg_reg <= seg_reg + 1'b1;
                end
                ffsa_pkg::S_SHWR: k_reg <= k_reg - 1'b1;
                ffsa_pkg::S_FCHK:
                begin
                    if (rdata.offset == foff_reg)
                    begin
                        first_reg <= i_reg;
                        k_reg <= i_reg;
                        tot_reg <= '0;
                    end
                    else if (i_reg + 1'b1 < n_cur)
                        i_reg <= i_reg + 1'b1;
                    else
                        st_reg <= ffsa_pkg::ST_NOT_FOUND;
                end
                ffsa_pkg::S_MLCHK:
                begin
                    if (rdata.free)
                    begin
                        first_reg <= first_reg - 1'b1;
                        k_reg <= first_reg - 1'b1;
                    end
                end
                ffsa_pkg::S_MRCHK:
                begin
                    if (k_reg == first_reg || k_reg <= i_reg || (rdata.free && k_reg < n_cur))
                    begin
                        tot_reg <= tot_reg + rdata.size;
                        if (k_reg == first_reg)
                            hold_reg <= '{offset: rdata.offset, size: '0, free: 1'b1};
                        last_reg <= k_reg;
                        k_reg <= k_reg + 1'b1;
                    end
                    else
                    begin
                        hold_reg.size <= tot_reg;
                        sub_reg[1] <= 1'b1;
                        k_reg <= first_reg + 1'b1;
                        count_reg[seg_reg] <= n_cur - (last_reg - first_reg);
                    end
                end
                ffsa_pkg::S_CPWR: k_reg <= k_reg + 1'b1;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hdl/ffsa_checker.sv -----
// Port-level checker for the allocator, bound to the top level.
// Depends on ffsa_pkg.
`default_nettype none
module ffsa_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_tvalid && s_tready))
        else $error("input taken while result pending");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1:0] != ffsa_pkg::ST_OK |-> m_tdata[25:2] == '0)
        else $error("error result carries grant fields");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("more than one result per command");
endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
